### rtl/core/rdq_pkg.sv
package rdq_pkg;

    // Operation codes carried in the mode field of a command.
    localparam logic [2:0] MODE_PUSH_REAR  = 3'd0;
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_REAR   = 3'd3;
    localparam logic [2:0] MODE_SHOW       = 3'd4;

    // Status codes reported with every result.
    localparam logic [2:0] STAT_OK          = 3'd0;
    localparam logic [2:0] STAT_NOW_EMPTY   = 3'd1;
    localparam logic [2:0] STAT_WAS_EMPTY   = 3'd2;
    localparam logic [2:0] STAT_FULL        = 3'd3;
    localparam logic [2:0] STAT_NOT_ALLOWED = 3'd4;

    // Restriction register values.
    localparam logic RESTRICT_INPUT  = 1'b0;
    localparam logic RESTRICT_OUTPUT = 1'b1;

    // Width of a stored value.
    localparam int DATA_W = 32;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [DATA_W-1:0] push_value;
    } rdq_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] entry_value;
        logic [2:0]               status;
        logic                     last;
    } rdq_rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_SHOW
    } rdq_state_t;

endpackage

### rtl/core/rdq_store.sv
module rdq_store
    import rdq_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic signed [DATA_W-1:0]   wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic signed [DATA_W-1:0]   rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    // Single write port; entries hold no meaning until written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Synchronous read; rd_data is registered and holds its value while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/restricted_deque.sv
// Bounded double-ended queue of signed 32-bit values, up to DEPTH entries held in a
// circular RAM. A command is taken when start is high and busy is low. Push rear, push
// front, pop front, pop rear and a disallowed or undefined mode each give one result
// in the cycle after the command, and the next command may follow at once, so these
// run at one transaction per cycle. Show of a non-empty queue raises busy and
// streams the entries front to rear, one per cycle through the RAM read port, with
// last set on the rear entry; busy stays high until the rear entry is given.
// Show of an empty queue gives one result with status "was empty". Results
// appear for exactly one cycle with rsp_valid and cannot be held off, so the receiver
// must take every one. The restriction register (cfg_wr_data) chooses input-restricted
// (0) or output-restricted (1) operation and should be written only while the block is
// idle; the contents are kept across a change.
module restricted_deque
    import rdq_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  rdq_cmd_t cmd,
    output rdq_rsp_t rsp,
    output logic     rsp_valid,
    input  logic     cfg_wr_en,
    input  logic     cfg_wr_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    rdq_state_t state_reg, state_next;

    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          restriction_reg;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_last_reg, rd_last_next;
    rdq_rsp_t      rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic                     accept;
    logic                     allowed;
    logic                     is_full;
    logic                     is_empty;
    logic                     show_active;
    logic                     issue;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_data;

    // Position head + offset folded back into the ring; the sum stays below twice DEPTH.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        begin
            sum = SW'(base) + SW'(offset);
            if (sum >= SW'(DEPTH))
            begin
                sum = sum - SW'(DEPTH);
            end
            ring_add = sum[AW-1:0];
        end
    endfunction

    assign accept   = start && !busy;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Which operations the current restriction admits.
    always_comb
    begin
        case (cmd.mode)
            MODE_PUSH_REAR:  allowed = 1'b1;
            MODE_POP_FRONT:  allowed = 1'b1;
            MODE_SHOW:       allowed = 1'b1;
            MODE_PUSH_FRONT: allowed = (restriction_reg == RESTRICT_OUTPUT);
            MODE_POP_REAR:   allowed = (restriction_reg == RESTRICT_INPUT);
            default:         allowed = 1'b0;
        endcase
    end

    // Next state of the controller.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && allowed && (cmd.mode == MODE_SHOW) && !is_empty)
                begin
                    state_next = ST_SHOW;
                end
            end
            ST_SHOW:
            begin
                if (rd_pend_reg && rd_last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Controller outputs.
    always_comb
    begin
        case (state_reg)
            ST_SHOW:
            begin
                busy        = 1'b1;
                show_active = 1'b1;
            end
            default:
            begin
                busy        = 1'b0;
                show_active = 1'b0;
            end
        endcase
    end

    assign issue   = show_active && (idx_reg < count_reg);
    assign rd_addr = ring_add(head_reg, idx_reg);

    // Queue update and result formation.
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_pend_next   = 1'b0;
        rd_last_next   = rd_last_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = ring_add(head_reg, count_reg);

        if (accept)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.entry_value = '0;
            rsp_next.status      = STAT_OK;
            rsp_next.last        = 1'b1;
            idx_next             = '0;
            if (!allowed)
            begin
                rsp_next.status = STAT_NOT_ALLOWED;
            end
            else
            begin
                case (cmd.mode)
                    MODE_PUSH_REAR:
                    begin
                        if (is_full)
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    MODE_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                        else
                        begin
                            head_next  = (head_reg == '0) ? AW'(DEPTH - 1)
                                                          : head_reg - AW'(1);
                            wr_addr    = head_next;
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    MODE_POP_FRONT, MODE_POP_REAR:
                    begin
                        if (is_empty)
                        begin
                            rsp_next.status = STAT_WAS_EMPTY;
                        end
                        else
                        begin
                            if (cmd.mode == MODE_POP_FRONT)
                            begin
                                head_next = (head_reg == AW'(DEPTH - 1)) ? '0
                                                                        : head_reg + AW'(1);
                            end
                            count_next = count_reg - CW'(1);
                            if (count_reg == CW'(1))
                            begin
                                rsp_next.status = STAT_NOW_EMPTY;
                            end
                        end
                    end
                    default:
                    begin
                        // Show: an empty queue answers at once, otherwise stream.
                        if (is_empty)
                        begin
                            rsp_next.status = STAT_WAS_EMPTY;
                        end
                        else
                        begin
                            rsp_valid_next = 1'b0;
                        end
                    end
                endcase
            end
        end

        // Show streaming: one read issued and one entry delivered per cycle.
        if (issue)
        begin
            idx_next     = idx_reg + CW'(1);
            rd_pend_next = 1'b1;
            rd_last_next = (idx_reg == count_reg - CW'(1));
        end
        if (rd_pend_reg)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.entry_value = rd_data;
            rsp_next.status      = STAT_OK;
            rsp_next.last        = rd_last_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            idx_reg         <= '0;
            restriction_reg <= RESTRICT_INPUT;
            rd_pend_reg     <= 1'b0;
            rd_last_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                restriction_reg <= cfg_wr_data;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    rdq_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.push_value),
        .rd_en   (issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

### rtl/core/rdq_checker.sv
module rdq_checker
    import rdq_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input rdq_cmd_t cmd,
    input rdq_rsp_t rsp,
    input logic     rsp_valid
);

    // Any accepted command other than show answers with a single final result next cycle.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.mode != MODE_SHOW))
        |=> (rsp_valid && rsp.last && (rsp.entry_value == '0)))
        else $error("non-show transaction did not give one final result");

    // An idle block with no new command produces nothing.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !rsp_valid)
        else $error("result appeared without a transaction");

    // A final result leaves the block ready for the next command.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.last) |-> !busy)
        else $error("busy still high with the final result");

    // Any status other than ok ends the transaction.
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != STAT_OK)) |-> rsp.last)
        else $error("non-ok status on a result that is not the last");

endmodule

bind restricted_deque rdq_checker u_rdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .rsp       (rsp),
    .rsp_valid (rsp_valid)
);
